@@ rtl/core/aes256_pkg.sv @@
package aes256_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned RndW = 4;

  localparam logic [2:0] CfgKey0 = 3'd0;
  localparam logic [2:0] CfgKey1 = 3'd1;
  localparam logic [2:0] CfgKey2 = 3'd2;
  localparam logic [2:0] CfgKey3 = 3'd3;
  localparam logic [2:0] CfgIvHi = 3'd4;
  localparam logic [2:0] CfgIvLo = 3'd5;
  localparam logic [2:0] CfgLoaded = 3'd6;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  typedef struct packed {
    logic start;
    logic decrypt;
    logic load_pad;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    gmul = r;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, p);
      p = gmul(p, p);
    end
    ginv = (x == 8'h00) ? 8'h00 : r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_calc(input logic [7:0] s);
    isbox_calc = ginv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_tab_t [256];

  function automatic sbox_tab_t build_sbox(input logic inv);
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? isbox_calc(i[7:0]) : sbox_calc(i[7:0]);
    end
    build_sbox = t;
  endfunction

  localparam sbox_tab_t SBox = build_sbox(1'b0);
  localparam sbox_tab_t ISBox = build_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBox[w[31:24]], SBox[w[23:16]], SBox[w[15:8]], SBox[w[7:0]]};
  endfunction

endpackage

@@ rtl/core/aes256_cbc_pkcs7_engine.sv @@
// an encrypt block gives its result after the initial key add and the full AES-256 round loop
// decrypt: six forward key schedule steps and the last round key add come first
// a full final encrypt block adds a pad block, started once the first result is taken
// one item at a time; the next item is accepted only after the result is taken and control is idle
// asynchronous active-low reset clears control, key, iv and chain state
module aes256_cbc_pkcs7_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic [4:0]  valid_bytes_i,
  input  logic        final_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_high_o,
  output logic [63:0] out_low_o,
  output logic [4:0]  out_bytes_o,
  output logic        out_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [255:0] key_q;
  logic [127:0] iv_q, chain_q, blk, pblk, res, outv_q;
  logic [4:0]   bytes_q;
  logic         loaded_q, last_q;
  aes256_pkg::dp_cmd_t    cmd;
  aes256_pkg::dp_status_t status;
  logic use_iv, pad, cap, lst, dec;
  logic [4:0] pad_n;
  logic [127:0] dec_in_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      iv_q     <= '0;
      loaded_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        aes256_pkg::CfgKey0:   key_q[255:192] <= cfg_data_i;
        aes256_pkg::CfgKey1:   key_q[191:128] <= cfg_data_i;
        aes256_pkg::CfgKey2:   key_q[127:64]  <= cfg_data_i;
        aes256_pkg::CfgKey3:   key_q[63:0]    <= cfg_data_i;
        aes256_pkg::CfgIvHi:   iv_q[127:64]   <= cfg_data_i;
        aes256_pkg::CfgIvLo:   iv_q[63:0]     <= cfg_data_i;
        aes256_pkg::CfgLoaded: loaded_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign blk = {block_high_i, block_low_i};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pblk[127-8*i -: 8] = (5'(i) < pad_n) ? blk[127-8*i -: 8] : 8'(5'd16 - pad_n);
    end
  end

  logic [127:0] chain_use;
  assign chain_use = use_iv ? iv_q : chain_q;

  aes256_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .valid_bytes_i,
    .final_block_i,
    .key_loaded_i (loaded_q),
    .out_valid_o,
    .out_stall_i,
    .status_i     (status),
    .cmd_o        (cmd),
    .use_iv_o     (use_iv),
    .pad_o        (pad),
    .pad_n_o      (pad_n),
    .cap_o        (cap),
    .last_o       (lst),
    .dec_o        (dec)
  );

  aes256_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i    (cmd),
    .blk_i    ((pad && !cmd.load_pad) ? pblk : blk),
    .chain_i  (cmd.load_pad ? chain_q : chain_use),
    .key_i    (key_q),
    .status_o (status),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else if (cmd.start && !cmd.load_pad && cmd.decrypt) begin
      chain_q <= blk;
    end else if (cap && !dec) begin
      chain_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.start && !cmd.load_pad) dec_in_q <= blk;
    if (cap) begin
      outv_q  <= res;
      last_q  <= lst;
      bytes_q <= (dec && lst && res[7:0] >= 8'd1 && res[7:0] <= 8'd16) ?
                 5'(8'd16 - res[7:0]) : 5'd16;
    end
  end

  assign out_high_o  = outv_q[127:64];
  assign out_low_o   = outv_q[63:0];
  assign out_bytes_o = bytes_q;
  assign out_last_o  = last_q;

`ifndef SYNTH
  a_cap_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap |=> out_valid_o) else $error("capture without result");
  a_dec_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.start && cmd.decrypt) |=> (chain_q == dec_in_q)) else $error("chain not loaded");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !out_valid_o) else $error("start with pending result");
`endif

endmodule

@@ rtl/core/aes256_datapath.sv @@
module aes256_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aes256_pkg::dp_cmd_t    cmd_i,
  input  logic [127:0]           blk_i,
  input  logic [127:0]           chain_i,
  input  logic [255:0]           key_i,
  output aes256_pkg::dp_status_t status_o,
  output logic [127:0]           res_o
);

  logic [127:0] st_q, st_d;
  logic [255:0] rk_q, rk_d;
  logic [7:0]   rc_q, rc_d;
  logic [3:0]   rnd_q, rnd_d;
  logic         busy_q, busy_d;
  logic         dec_q, dec_d;
  logic         pre_q, pre_d;
  logic         done_q, done_d;
  logic [127:0] chain_q, chain_d;

  logic [127:0] sr, sb, mc, isr, isb, imc, enc_next, dec_next;
  logic [127:0] cur_rk;
  logic [255:0] fwd_key, bwd_key;
  logic [7:0]   rc_back;

  function automatic logic [255:0] key_fwd(input logic [255:0] k, input logic [7:0] rc);
    logic [31:0] w [8];
    logic [31:0] n [8];
    for (int i = 0; i < 8; i++) w[i] = k[255-32*i -: 32];
    n[0] = w[0] ^ aes256_pkg::sub_word({w[7][23:0], w[7][31:24]}) ^ {rc, 24'h0};
    for (int i = 1; i < 4; i++) n[i] = w[i] ^ n[i-1];
    n[4] = w[4] ^ aes256_pkg::sub_word(n[3]);
    for (int i = 5; i < 8; i++) n[i] = w[i] ^ n[i-1];
    key_fwd = {n[0], n[1], n[2], n[3], n[4], n[5], n[6], n[7]};
  endfunction

  function automatic logic [255:0] key_bwd(input logic [255:0] k, input logic [7:0] rc);
    logic [31:0] n [8];
    logic [31:0] w [8];
    for (int i = 0; i < 8; i++) n[i] = k[255-32*i -: 32];
    for (int i = 7; i > 4; i--) w[i] = n[i] ^ n[i-1];
    w[4] = n[4] ^ aes256_pkg::sub_word(n[3]);
    for (int i = 3; i > 0; i--) w[i] = n[i] ^ n[i-1];
    w[0] = n[0] ^ aes256_pkg::sub_word({w[7][23:0], w[7][31:24]}) ^ {rc, 24'h0};
    key_bwd = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
  endfunction

  // rk_q holds the 8-word window; odd rounds use the low half, even rounds the high half
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[127-8*(i+4*c) -: 8]            = st_q[127-8*(i+4*((c+i)&3)) -: 8];
        isr[127-8*(i+4*((c+i)&3)) -: 8]   = st_q[127-8*(i+4*c) -: 8];
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[127-8*i -: 8]  = aes256_pkg::SBox[sr[127-8*i -: 8]];
      isb[127-8*i -: 8] = aes256_pkg::ISBox[isr[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        mc[127-8*(4*c+j) -: 8] =
          aes256_pkg::gmul(sb[127-8*(4*c+j) -: 8], 8'd2) ^
          aes256_pkg::gmul(sb[127-8*(4*c+((j+1)&3)) -: 8], 8'd3) ^
          sb[127-8*(4*c+((j+2)&3)) -: 8] ^ sb[127-8*(4*c+((j+3)&3)) -: 8];
      end
    end
  end

  always_comb begin
    logic [127:0] t;
    rc_back = {1'b0, rc_q[7:1]} ^ (rc_q[0] ? 8'h8d : 8'h00);
    fwd_key = key_fwd(rk_q, rc_q);
    bwd_key = key_bwd(rk_q, rc_back);
    cur_rk = rnd_q[0] ? rk_q[127:0] : rk_q[255:128];
    enc_next = ((rnd_q == 4'(aes256_pkg::NumRounds)) ? sb : mc) ^ cur_rk;
    t = isb ^ cur_rk;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        imc[127-8*(4*c+j) -: 8] =
          aes256_pkg::gmul(t[127-8*(4*c+j) -: 8], 8'd14) ^
          aes256_pkg::gmul(t[127-8*(4*c+((j+1)&3)) -: 8], 8'd11) ^
          aes256_pkg::gmul(t[127-8*(4*c+((j+2)&3)) -: 8], 8'd13) ^
          aes256_pkg::gmul(t[127-8*(4*c+((j+3)&3)) -: 8], 8'd9);
      end
    end
    dec_next = (rnd_q == 4'(aes256_pkg::NumRounds)) ? (t ^ chain_q) : imc;
  end

  // decrypt first sweeps the schedule forward to the second to last window
  always_comb begin
    st_d    = st_q;
    rk_d    = rk_q;
    rc_d    = rc_q;
    rnd_d   = rnd_q;
    busy_d  = busy_q;
    dec_d   = dec_q;
    pre_d   = pre_q;
    chain_d = chain_q;
    done_d  = 1'b0;
    if (cmd_i.start) begin
      busy_d  = 1'b1;
      dec_d   = cmd_i.decrypt;
      chain_d = chain_i;
      rnd_d   = 4'd0;
      rc_d    = 8'h01;
      if (cmd_i.decrypt) begin
        pre_d = 1'b1;
        rk_d  = key_i;
        st_d  = blk_i;
      end else begin
        pre_d = 1'b0;
        rk_d  = key_i;
        st_d  = (cmd_i.load_pad ? {16{8'h10}} : blk_i) ^ chain_i ^ key_i[255:128];
        rnd_d = 4'd1;
      end
    end else if (busy_q && pre_q) begin
      // walk the schedule forward to find the last round key window
      if (rnd_q == 4'd6) begin
        pre_d = 1'b0;
        st_d  = st_q ^ fwd_key[255:128];
        rnd_d = 4'd1;
      end else begin
        rk_d  = fwd_key;
        rc_d  = aes256_pkg::xtime(rc_q);
        rnd_d = rnd_q + 4'd1;
      end
    end else if (busy_q) begin
      if (dec_q) st_d = dec_next;
      else       st_d = enc_next;
      if (rnd_q == 4'(aes256_pkg::NumRounds)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rnd_d = rnd_q + 4'd1;
        if (!dec_q && rnd_q[0]) begin
          rk_d = fwd_key;
          rc_d = aes256_pkg::xtime(rc_q);
        end else if (dec_q && !rnd_q[0]) begin
          rk_d = bwd_key;
          rc_d = rc_back;
        end
      end
    end
  end

  assign status_o.done = done_q;
  assign res_o = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pre_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pre_q  <= pre_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    rk_q    <= rk_d;
    rc_q    <= rc_d;
    dec_q   <= dec_d;
    chain_q <= chain_d;
  end

endmodule

@@ rtl/core/aes256_ctrl.sv @@
module aes256_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   command_i,
  input  logic [4:0]             valid_bytes_i,
  input  logic                   final_block_i,
  input  logic                   key_loaded_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  aes256_pkg::dp_status_t status_i,
  output aes256_pkg::dp_cmd_t    cmd_o,
  output logic                   use_iv_o,
  output logic                   pad_o,
  output logic [4:0]             pad_n_o,
  output logic                   cap_o,
  output logic                   last_o,
  output logic                   dec_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       inmsg_q, inmsg_d;
  logic       extra_q, extra_d;
  logic       last_q, last_d;
  logic       dec_q, dec_d;
  logic       ov_q, ov_d;
  logic       accept, skip;
  logic [4:0] n;

  assign in_stall_o = (state_q != StIdle) || ov_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign skip       = !key_loaded_i ||
                      (command_i == aes256_pkg::CmdEncrypt && final_block_i &&
                       valid_bytes_i == 5'd0 && !inmsg_q);
  assign n          = (command_i == aes256_pkg::CmdEncrypt && final_block_i) ?
                      ((valid_bytes_i > 5'd16) ? 5'd16 : valid_bytes_i) : 5'd16;
  assign pad_n_o    = n;
  assign use_iv_o   = !inmsg_q;
  assign out_valid_o = ov_q;
  assign last_o     = last_q;
  assign dec_o      = dec_q;

  always_comb begin
    state_d = state_q;
    inmsg_d = inmsg_q;
    extra_d = extra_q;
    last_d  = last_q;
    dec_d   = dec_q;
    ov_d    = ov_q && out_stall_i;
    cmd_o   = '0;
    pad_o   = 1'b0;
    cap_o   = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept && !skip) begin
          cmd_o.start   = 1'b1;
          cmd_o.decrypt = command_i;
          pad_o         = (n != 5'd16);
          inmsg_d       = !final_block_i;
          dec_d         = command_i;
          extra_d       = command_i == aes256_pkg::CmdEncrypt && final_block_i &&
                          n == 5'd16;
          last_d        = final_block_i && !extra_d;
          state_d       = StRun;
        end
      end
      StRun: begin
        if (status_i.done) begin
          cap_o   = 1'b1;
          ov_d    = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ov_q) begin
          if (extra_q) begin
            cmd_o.start    = 1'b1;
            cmd_o.load_pad = 1'b1;
            extra_d        = 1'b0;
            last_d         = 1'b1;
            state_d        = StRun;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      inmsg_q <= 1'b0;
      extra_q <= 1'b0;
      last_q  <= 1'b0;
      dec_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      inmsg_q <= inmsg_d;
      extra_q <= extra_d;
      last_q  <= last_d;
      dec_q   <= dec_d;
      ov_q    <= ov_d;
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> in_stall_o) else $error("accept while busy");
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.done |-> (state_q == StRun)) else $error("stray done");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.done |=> out_valid_o) else $error("result lost");
`endif

endmodule
